@@ rtl/iso_directory_record_parser_core_defines.svh @@
// Assertion helpers shared by the parser RTL.
// Both macros expect clk and rst_n to be visible in the module that uses them.
`ifndef ISO_DIRECTORY_RECORD_PARSER_CORE_DEFINES_SVH
`define ISO_DIRECTORY_RECORD_PARSER_CORE_DEFINES_SVH

// Same-cycle implication
`define IDRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IDRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/idrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package idrp_pkg;

    // Sector geometry
    localparam int SECTOR_BYTES = 2048;
    localparam int SECTOR_POS_W = $clog2(SECTOR_BYTES);
    localparam logic [SECTOR_POS_W-1:0] SECTOR_LAST = SECTOR_POS_W'(SECTOR_BYTES - 1);

    // Record layout
    localparam logic [7:0] POS_LENGTH     = 8'd0;
    localparam logic [7:0] POS_START_LO   = 8'd2;
    localparam logic [7:0] POS_START_HI   = 8'd5;
    localparam logic [7:0] POS_SIZE_LO    = 8'd10;
    localparam logic [7:0] POS_SIZE_HI    = 8'd13;
    localparam logic [7:0] POS_FLAGS      = 8'd25;
    localparam logic [7:0] POS_NAME_LEN   = 8'd32;
    localparam logic [7:0] POS_NAME_FIRST = 8'd33;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam int         FLAG_DIR_BIT   = 1;

    // Result kinds
    localparam logic RESULT_NAME    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Config register map
    localparam logic [1:0] ADDR_SKIP_ENTRIES = 2'd0;
    localparam logic [1:0] SKIP_ENTRIES_RESET = 2'd2;
    localparam logic [1:0] SEEN_MAX = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [31:0] start_sector;
        logic [31:0] file_size;
        logic        is_directory;
        logic        last_of_run;
    } result_t;

    // Up to two results produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first_res;
        result_t    second_res;
    } result_pair_t;

    typedef struct packed {
        logic [7:0]              rec_pos;
        logic [7:0]              rec_len;
        logic [SECTOR_POS_W-1:0] sec_pos;
        logic                    pad;
        logic [1:0]              seen;
        logic [31:0]             start;
        logic [31:0]             size;
        logic                    dir;
        logic [7:0]              name_len;
        logic                    name_stop;
    } parse_state_t;

endpackage

`default_nettype wire

@@ rtl/idrp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "iso_directory_record_parser_core_defines.svh"

module idrp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 first_of_extent,
    input  logic                 last_of_extent,
    input  logic [1:0]           skip_entries,
    input  logic                 queue_room,
    output idrp_pkg::result_pair_t push
);
    import idrp_pkg::*;

    logic         item_valid_reg, item_valid_next;
    logic [7:0]   item_byte_reg;
    logic         item_first_reg;
    logic         item_last_reg;
    logic         advance;
    logic         in_fire;

    parse_state_t state_reg, state_next;
    parse_state_t cur;
    parse_state_t upd;
    logic [7:0]   p;
    logic [7:0]   b;
    logic [4:0]   lane_shift;
    logic         emitting;
    logic         name_emit;
    logic         sum_emit;
    result_t      name_res;
    result_t      sum_res;

    // Input register handshake
    assign advance  = item_valid_reg && queue_room;
    assign in_ready = !item_valid_reg || queue_room;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_fire)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_byte_reg  <= data_byte;
            item_first_reg <= first_of_extent;
            item_last_reg  <= last_of_extent;
        end
    end

    // Record decode for the byte in the input register
    assign b          = item_byte_reg;
    assign cur        = item_first_reg ? '0 : state_reg;
    assign p          = cur.rec_pos;
    assign lane_shift = {p[1:0] - 2'd2, 3'b000};
    assign emitting   = (cur.seen >= skip_entries);

    always_comb
    begin
        upd       = cur;
        name_emit = 1'b0;
        sum_emit  = 1'b0;

        if (cur.pad)
        begin
            // rest of sector is padding
        end
        else if (p == POS_LENGTH && b == 8'd0)
        begin
            upd.pad = 1'b1;
        end
        else
        begin
            if (p == POS_LENGTH)
            begin
                upd.rec_len   = b;
                upd.start     = '0;
                upd.size      = '0;
                upd.dir       = 1'b0;
                upd.name_len  = '0;
                upd.name_stop = 1'b0;
            end
            else if (p >= POS_START_LO && p <= POS_START_HI)
            begin
                upd.start = cur.start | ({24'd0, b} << lane_shift);
            end
            else if (p >= POS_SIZE_LO && p <= POS_SIZE_HI)
            begin
                upd.size = cur.size | ({24'd0, b} << lane_shift);
            end
            else if (p == POS_FLAGS)
            begin
                upd.dir = b[FLAG_DIR_BIT];
            end
            else if (p == POS_NAME_LEN)
            begin
                upd.name_len = b;
            end
            else if (p >= POS_NAME_FIRST && (p - POS_NAME_FIRST) < cur.name_len
                     && !cur.name_stop)
            begin
                if (b == CHAR_SEMICOLON)
                    upd.name_stop = 1'b1;
                else
                    name_emit = emitting;
            end

            // end of record (length counts the length byte itself)
            if (({1'b0, p} + 9'd1) >= {1'b0, upd.rec_len})
            begin
                sum_emit    = emitting;
                upd.rec_pos = '0;
                if (cur.seen < SEEN_MAX)
                    upd.seen = cur.seen + 2'd1;
            end
            else
            begin
                upd.rec_pos = p + 8'd1;
            end
        end

        // sector position wraps and ends padding
        if (cur.sec_pos == SECTOR_LAST)
        begin
            upd.sec_pos = '0;
            upd.pad     = 1'b0;
        end
        else
        begin
            upd.sec_pos = cur.sec_pos + 1'b1;
        end
    end

    // Result formation
    always_comb
    begin
        name_res              = '0;
        name_res.kind         = RESULT_NAME;
        name_res.name_char    = b;
        name_res.last_of_run  = !sum_emit;

        sum_res               = '0;
        sum_res.kind          = RESULT_SUMMARY;
        sum_res.start_sector  = upd.start;
        sum_res.file_size     = upd.size;
        sum_res.is_directory  = upd.dir;
        sum_res.last_of_run   = 1'b1;

        push = '0;
        if (advance)
        begin
            if (name_emit)
            begin
                push.count      = sum_emit ? 2'd2 : 2'd1;
                push.first_res  = name_res;
                push.second_res = sum_res;
            end
            else if (sum_emit)
            begin
                push.count     = 2'd1;
                push.first_res = sum_res;
            end
        end
    end

    // State update; end of extent clears everything
    always_comb
    begin
        state_next = state_reg;
        if (advance)
            state_next = item_last_reg ? '0 : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    `IDRP_ASSERT_IMP(a_pair_order, push.count == 2'd2, push.first_res.kind == RESULT_NAME && push.second_res.kind == RESULT_SUMMARY, "two results must be name then summary")
    `IDRP_ASSERT_NXT(a_last_clears, advance && item_last_reg, state_reg == '0, "parse state not cleared at extent end")
    `IDRP_ASSERT_IMP(a_push_on_advance, push.count != 2'd0, advance, "results pushed without a byte leaving the input register")

endmodule

`default_nettype wire

@@ rtl/idrp_result_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "iso_directory_record_parser_core_defines.svh"

module idrp_result_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  idrp_pkg::result_pair_t push,
    output logic                   queue_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output idrp_pkg::result_t      head
);
    import idrp_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;
    logic                   pop;

    // Room for a full pair of results
    assign queue_room   = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first_res;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second_res;
    end

    `IDRP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "result queue over depth")
    `IDRP_ASSERT_IMP(a_push_room, push.count != 2'd0, queue_room, "push without room for a pair")
    `IDRP_ASSERT_IMP(a_run_marks, push.count == 2'd2, !push.first_res.last_of_run && push.second_res.last_of_run, "run end mark misplaced")
    `IDRP_ASSERT_IMP(a_single_mark, push.count == 2'd1, push.first_res.last_of_run, "single result lacks run end mark")

endmodule

`default_nettype wire

@@ rtl/iso_directory_record_parser_core.sv @@
// Channel   Handshake               Payload
// input     in_valid / in_ready     data_byte, first_of_extent, last_of_extent
// output    out_valid / out_ready   result_kind, name_char, start_sector, file_size,
//                                   is_directory, last_of_run
// config    APB psel/penable        paddr, pwdata, prdata (skip_entries at 0x0)
//
// One byte per cycle enters while in_ready; it is registered, then its results are queued.
// A byte yields zero, one or two results; the queue drains one result per cycle while out_ready.
// Input stalls only while a held byte waits for two free slots in the four-entry queue.
// Reset (rst_n, async low) clears parse state and queue; skip_entries resets to 2.
`timescale 1ns / 1ps
`default_nettype none

module iso_directory_record_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_of_extent,
    input  logic        last_of_extent,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  name_char,
    output logic [31:0] start_sector,
    output logic [31:0] file_size,
    output logic        is_directory,
    output logic        last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import idrp_pkg::*;

    logic         [1:0] skip_entries_reg, skip_entries_next;
    logic               cfg_write;
    result_pair_t       push;
    result_t            head;
    logic               queue_room;

    // Config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_SKIP_ENTRIES);
    assign skip_entries_next = cfg_write ? pwdata[1:0] : skip_entries_reg;
    assign prdata    = (paddr == ADDR_SKIP_ENTRIES) ? {30'd0, skip_entries_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_entries_reg <= SKIP_ENTRIES_RESET;
        else
            skip_entries_reg <= skip_entries_next;
    end

    // Record parser
    idrp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_extent (first_of_extent),
        .last_of_extent  (last_of_extent),
        .skip_entries    (skip_entries_reg),
        .queue_room      (queue_room),
        .push            (push)
    );

    // Result queue
    idrp_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .queue_room (queue_room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign result_kind  = head.kind;
    assign name_char    = head.name_char;
    assign start_sector = head.start_sector;
    assign file_size    = head.file_size;
    assign is_directory = head.is_directory;
    assign last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

@@ dv/idrp_result_checker.sv @@
`timescale 1ns / 1ps

// Watches the byte stream, the result stream and the register port of the
// directory record parser; keeps its own parse state and checks every result.
module idrp_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_of_extent,
    input  logic        last_of_extent,
    // results
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [7:0]  name_char,
    input  logic [31:0] start_sector,
    input  logic [31:0] file_size,
    input  logic        is_directory,
    input  logic        last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // status for the test
    output int          mismatches,
    output int          outstanding,
    output int          name_count,
    output int          summary_count
);
    import idrp_pkg::*;

    localparam int PRINT_CAP = 200;

    // Register copy and parse state
    logic [1:0]              skip_cfg;
    logic [7:0]              rec_pos;
    logic [7:0]              rec_len;
    logic [SECTOR_POS_W-1:0] sec_pos;
    logic                    pad_skip;
    logic [1:0]              records_seen;
    logic [31:0]             start_cap;
    logic [31:0]             size_cap;
    logic                    dir_flag;
    logic [7:0]              name_len;
    logic                    name_stop;

    result_t expected_results[$];

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic clear_parse_state();
        rec_pos      = '0;
        rec_len      = '0;
        sec_pos      = '0;
        pad_skip     = 1'b0;
        records_seen = '0;
        start_cap    = '0;
        size_cap     = '0;
        dir_flag     = 1'b0;
        name_len     = '0;
        name_stop    = 1'b0;
    endtask

    // Advance the parse state by one byte and queue the results it causes
    task automatic parse_directory_byte(input logic [7:0] b, input logic first,
                                        input logic last);
        int      p;
        logic    emit;
        int      n;
        result_t batch [2];

        n = 0;
        if (first)
            clear_parse_state();

        if (pad_skip) begin
            // rest of sector is padding
        end else if (rec_pos == POS_LENGTH && b == 8'h00) begin
            pad_skip = 1'b1;
        end else begin
            p    = rec_pos;
            emit = (records_seen >= skip_cfg);
            if (p == POS_LENGTH) begin
                rec_len   = b;
                start_cap = '0;
                size_cap  = '0;
                dir_flag  = 1'b0;
                name_len  = '0;
                name_stop = 1'b0;
            end else if (p >= POS_START_LO && p <= POS_START_HI) begin
                start_cap |= 32'(b) << (8 * (p - POS_START_LO));
            end else if (p >= POS_SIZE_LO && p <= POS_SIZE_HI) begin
                size_cap |= 32'(b) << (8 * (p - POS_SIZE_LO));
            end else if (p == POS_FLAGS) begin
                dir_flag = b[FLAG_DIR_BIT];
            end else if (p == POS_NAME_LEN) begin
                name_len = b;
            end else if (p >= POS_NAME_FIRST && (p - POS_NAME_FIRST) < name_len
                         && !name_stop) begin
                // name runs up to the version separator
                if (b == CHAR_SEMICOLON) begin
                    name_stop = 1'b1;
                end else if (emit) begin
                    batch[n] = '{kind: RESULT_NAME, name_char: b, start_sector: '0,
                                 file_size: '0, is_directory: 1'b0, last_of_run: 1'b0};
                    n++;
                end
            end

            // record ends at its last byte, or early for a short length
            if (p + 1 >= rec_len) begin
                if (emit) begin
                    batch[n] = '{kind: RESULT_SUMMARY, name_char: '0,
                                 start_sector: start_cap, file_size: size_cap,
                                 is_directory: dir_flag, last_of_run: 1'b0};
                    n++;
                end
                if (records_seen != SEEN_MAX)
                    records_seen++;
                rec_pos = '0;
            end else begin
                rec_pos = 8'(p + 1);
            end
        end

        // sector boundary ends any padding run
        if (sec_pos == SECTOR_LAST) begin
            sec_pos  = '0;
            pad_skip = 1'b0;
        end else begin
            sec_pos++;
        end

        if (last)
            clear_parse_state();

        if (n > 0)
            batch[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(batch[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            skip_cfg = SKIP_ENTRIES_RESET;
            clear_parse_state();
            expected_results.delete();
            outstanding <= 0;
        end else begin
            // result transaction against the oldest expectation
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, kind",
                                    32'(result_kind), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
                    if (name_char !== want.name_char)
                        report_mismatch("name_char", 32'(name_char), 32'(want.name_char));
                    if (start_sector !== want.start_sector)
                        report_mismatch("start_sector", start_sector, want.start_sector);
                    if (file_size !== want.file_size)
                        report_mismatch("file_size", file_size, want.file_size);
                    if (is_directory !== want.is_directory)
                        report_mismatch("is_directory", 32'(is_directory),
                                        32'(want.is_directory));
                    if (last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(last_of_run),
                                        32'(want.last_of_run));
                    if (want.kind == RESULT_SUMMARY)
                        summary_count++;
                    else
                        name_count++;
                end
            end

            // register write
            if (psel && penable && pwrite && pready && paddr == ADDR_SKIP_ENTRIES)
                skip_cfg = pwdata[1:0];

            // byte transaction
            if (in_valid && in_ready)
                parse_directory_byte(data_byte, first_of_extent, last_of_extent);

            outstanding <= expected_results.size();
        end
    end

endmodule

@@ dv/tb_iso_directory_record_parser_core.sv @@
`timescale 1ns / 1ps

module tb_iso_directory_record_parser_core;
    import idrp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 96;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
        logic       last;
    } extent_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        first_of_extent = 1'b0;
    logic        last_of_extent = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  name_char;
    logic [31:0] start_sector;
    logic [31:0] file_size;
    logic        is_directory;
    logic        last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int name_count;
    int summary_count;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int extents_sent = 0;
    int items_built = 0;

    extent_byte_t extent_q[$];

    iso_directory_record_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_extent (first_of_extent),
        .last_of_extent  (last_of_extent),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .name_char       (name_char),
        .start_sector    (start_sector),
        .file_size       (file_size),
        .is_directory    (is_directory),
        .last_of_run     (last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    idrp_result_checker u_result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_extent (first_of_extent),
        .last_of_extent  (last_of_extent),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .name_char       (name_char),
        .start_sector    (start_sector),
        .file_size       (file_size),
        .is_directory    (is_directory),
        .last_of_run     (last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .name_count      (name_count),
        .summary_count   (summary_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Result side backpressure
    always @(posedge clk)
    begin
        out_ready <= !($urandom_range(99, 0) < recv_stall_pct);
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles, %0d results still owed",
                     cycle_count, outstanding);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first,
                             input logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        data_byte       <= value;
        first_of_extent <= first;
        last_of_extent  <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Sender holds off until every owed result is out and the pipe is quiet
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_skip_entries(input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SKIP_ENTRIES;
        pwdata  <= {30'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // One directory record, mostly well formed, sometimes short or with the
    // name running past the record end
    function automatic void add_record(input bit long_form);
        logic [7:0]  rec [256];
        logic [31:0] start_val;
        logic [31:0] size_val;
        int          nlen;
        int          rlen;
        for (int i = 0; i < 256; i++)
            rec[i] = 8'($urandom);
        start_val = pick_word();
        size_val  = pick_word();
        case ($urandom_range(9, 0))
            0:       nlen = 0;
            1:       nlen = $urandom_range(222, 13);
            default: nlen = $urandom_range(12, 1);
        endcase
        for (int i = 0; i < nlen; i++)
        begin
            case ($urandom_range(19, 0))
                0:       rec[POS_NAME_FIRST + i] = CHAR_SEMICOLON;
                1:       rec[POS_NAME_FIRST + i] = 8'($urandom);
                2:       rec[POS_NAME_FIRST + i] = 8'h2E;
                default: rec[POS_NAME_FIRST + i] = 8'h41 + 8'($urandom_range(25, 0));
            endcase
        end

        if (long_form)
            rlen = $urandom_range(255, 34);
        else
        begin
            case ($urandom_range(19, 0))
                0, 1, 2: rlen = $urandom_range(33, 1);
                3, 4:    rlen = (nlen >= 2) ? $urandom_range(32 + nlen, 34) : 34;
                5:       rlen = $urandom_range(255, 1);
                default:
                begin
                    rlen = 33 + nlen;
                    if ($urandom_range(3, 0) == 0)
                        rlen += $urandom_range(20, 1);
                    if (rlen > 255)
                        rlen = 255;
                end
            endcase
        end

        rec[POS_LENGTH] = 8'(rlen);
        for (int i = 0; i < 4; i++)
        begin
            rec[POS_START_LO + i] = start_val[8 * i +: 8];
            rec[POS_SIZE_LO + i]  = size_val[8 * i +: 8];
        end
        rec[POS_NAME_LEN] = 8'(nlen);

        for (int i = 0; i < rlen; i++)
            extent_q.push_back('{value: rec[i], first: 1'b0, last: 1'b0});
    endfunction

    // Zero length byte, then a short run of filler that is skipped as padding
    function automatic void add_sector_padding();
        int fill;
        fill = $urandom_range(12, 0);
        extent_q.push_back('{value: 8'h00, first: 1'b0, last: 1'b0});
        for (int i = 0; i < fill; i++)
            extent_q.push_back('{value: 8'($urandom), first: 1'b0, last: 1'b0});
    endfunction

    task automatic send_extent(input bit mark_first, input bit mark_last);
        int i;
        for (i = 0; i < extent_q.size(); i++)
            send_byte(extent_q[i].value, extent_q[i].first | (mark_first && i == 0),
                      extent_q[i].last | (mark_last && i == extent_q.size() - 1));
        extent_q.delete();
        extents_sent++;
    endtask

    // Mostly well-formed extents; some truncated, unterminated or pure noise.
    // Each extent is trimmed so the phase stays within its byte budget.
    task automatic run_phase(input int quota);
        int target;
        int kind;
        int nrec;
        int cut;
        bit well_formed;
        bit mark_last;
        target = items_built + quota;
        while (items_built < target)
        begin
            kind        = $urandom_range(99, 0);
            well_formed = (kind >= 8);
            mark_last   = well_formed;
            if (!well_formed)
            begin
                nrec = $urandom_range(40, 1);
                for (int r = 0; r < nrec; r++)
                    extent_q.push_back('{value: 8'($urandom),
                                         first: $urandom_range(19, 0) == 0,
                                         last: $urandom_range(19, 0) == 0});
            end
            else
            begin
                nrec = $urandom_range(5, 1);
                for (int r = 0; r < nrec; r++)
                begin
                    add_record(1'b0);
                    if ($urandom_range(24, 0) == 0)
                        add_sector_padding();
                end
                if (kind < 18)
                begin
                    cut = $urandom_range(extent_q.size(), 1);
                    while (extent_q.size() > cut)
                        void'(extent_q.pop_back());
                end
                else if (kind < 25)
                    mark_last = 1'b0;
            end
            cut = target - items_built;
            while (extent_q.size() > cut)
                void'(extent_q.pop_back());
            items_built += extent_q.size();
            send_extent(well_formed, mark_last);
        end
    endtask

    initial
    begin
        logic [7:0] short_rec [14];
        short_rec = '{8'h0E, 8'h00, 8'h01, 8'h00, 8'h00, 8'h80, 8'h5A,
                      8'hA5, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset skip count: two silent one-byte records, then an all-zero summary
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        // padding byte that also closes the extent
        send_byte(8'h00, 1'b0, 1'b1);
        // both marks on one byte, still inside the skipped records
        send_byte(8'h01, 1'b1, 1'b1);

        wait_for_drain();
        write_skip_entries(2'd0);
        // both marks on one byte with output enabled
        send_byte(8'h01, 1'b1, 1'b1);
        // short record: start and size captured, name never reached
        for (int i = 0; i < 14; i++)
            send_byte(short_rec[i], i == 0, 1'b0);
        // extent ends mid-record: no summary
        send_byte(8'h22, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);

        // One long record, then mixed extents, no idling
        add_record(1'b1);
        items_built += extent_q.size();
        send_extent(1'b1, 1'b1);
        run_phase(PHASE_ITEMS);

        // Sender mostly idle, most records skipped
        wait_for_drain();
        write_skip_entries(2'd3);
        send_idle_pct = 81;
        run_phase(PHASE_ITEMS);

        // Receiver mostly stalled, with a full drain in the middle
        wait_for_drain();
        write_skip_entries(2'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_phase(PHASE_ITEMS / 2);
        wait_for_drain();
        run_phase(PHASE_ITEMS / 2);

        // Light idling on both sides
        wait_for_drain();
        write_skip_entries(2'd2);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_phase(PHASE_ITEMS);

        // Back to back at a random skip count
        wait_for_drain();
        write_skip_entries(2'($urandom_range(3, 0)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(PHASE_ITEMS);

        wait_for_drain();

        $display("Sent %0d bytes in %0d extents across skip counts 0 to 3 and four idle mixes",
                 bytes_sent, extents_sent);
        $display("Checked %0d name characters and %0d entry summaries",
                 name_count, summary_count);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
